### design/ibal_pkg.sv
// ----------------------------------------------------------------------------
// ibal_pkg
// Shared types, codes and helpers of the indexed block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ibal_pkg;

    // bitmap word width and its bit-index width
    localparam int WORD  = 32;
    localparam int WBITS = 5;

    // width of a file size (0 .. 64) and of the result block number
    localparam int SZW  = 7;
    localparam int OBLK = 10;

    typedef enum logic [1:0] {
        MODE_ALLOC  = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_LOOKUP = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_TABLE_FULL = 3'd1,
        ST_NOT_FOUND  = 3'd2,
        ST_DISK_FULL  = 3'd3,
        ST_RANGE      = 3'd4
    } t_status;

    // index of the set bit of a one-hot word
    function automatic logic [WBITS-1:0] f_onehot_idx(input logic [WORD-1:0] w);
        logic [WBITS-1:0] r;
        r = '0;
        for (int k = 0; k < WORD; k++) begin
            if (w[k]) begin
                r = r | WBITS'(k);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### design/indexed_block_allocator.sv
// ----------------------------------------------------------------------------
// indexed_block_allocator
// Free-block bitmap, file table and per-file block index behind one sequencer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | to block  | i_in_valid / o_in_stall  | i_mode i_file_key i_block_count
//          |           |                         | i_entry_index
//  out     | from block| o_out_valid / i_out_stall| o_status o_block_number
//          |           |                         | o_file_blocks o_last
//
//  One request at a time. Allocate: reads bitmap words in turn and grants one
//  block per set bit until the count is met. Delete: searches the table slot
//  by slot, frees each block of the file in the bitmap, then moves each later
//  slot and its index entries down one. Lookup: searches the table, then reads
//  the requested index entry. After reset a clearing pass marks every block
//  free; o_in_stall stays high meanwhile. A stalled output beat holds
//  the sequencer; a new request beat is taken only once the previous request
//  is done and its final result beat has left the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_block_allocator
    import ibal_pkg::*;
#(
    parameter int FILE_SLOTS      = 64,
    parameter int DISK_BLOCKS     = 1024,
    parameter int BLOCKS_PER_FILE = 64
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire logic [1:0]      i_mode,
    input  wire logic [15:0]     i_file_key,
    input  wire logic [7:0]      i_block_count,
    input  wire logic [5:0]      i_entry_index,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output logic [2:0]           o_status,
    output logic [OBLK-1:0]      o_block_number,
    output logic [SZW-1:0]       o_file_blocks,
    output logic                 o_last
);

    localparam int ROWS      = (DISK_BLOCKS + WORD - 1) / WORD;
    localparam int RW        = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int BLKW      = RW + WBITS;
    localparam int SW        = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1;
    localparam int FW        = $clog2(FILE_SLOTS + 1);
    localparam int EW        = (BLOCKS_PER_FILE > 1) ? $clog2(BLOCKS_PER_FILE) : 1;
    localparam int FTW       = $clog2(DISK_BLOCKS + 1);
    localparam int CW        = (FTW > SZW) ? FTW : SZW;
    localparam int LAST_BITS = DISK_BLOCKS - (ROWS - 1) * WORD;
    localparam logic [WORD-1:0] LAST_MASK = WORD'((64'd1 << LAST_BITS) - 64'd1);
    localparam int TW        = 16 + SZW;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_RESP,
        S_A_RD, S_A_LOAD, S_A_SCAN,
        S_FIND_RD, S_FIND_CMP,
        S_LK_RD, S_LK_OUT,
        S_DF_RD, S_DF_IDX, S_DF_BRD, S_DF_BMOD,
        S_CP_TRD, S_CP_TAB, S_CP_IRD, S_CP_IWR
    } t_state;

    t_state             r_state;
    logic [RW-1:0]      r_row;
    logic [WORD-1:0]    r_word;
    logic [FW-1:0]      r_files;
    logic [FTW-1:0]     r_free;
    logic [SW-1:0]      r_slot;
    logic [15:0]        r_key;
    t_mode              r_mode;
    logic [5:0]         r_entry;
    logic [SZW-1:0]     r_n;
    logic [SZW-1:0]     r_cnt;     // blocks granted / freed / copied
    logic [SZW-1:0]     r_size;    // deleted file size
    logic [SZW-1:0]     r_csize;   // size of slot being moved
    logic [RW-1:0]      r_bm_row;
    logic [WBITS-1:0]   r_bm_bit;

    logic               r_out_valid;
    t_status            r_status;
    logic [BLKW-1:0]    r_blk;
    logic [SZW-1:0]     r_fb;
    logic               r_last;

    // memory ports
    logic               bm_we;
    logic [RW-1:0]      bm_waddr, bm_raddr;
    logic [WORD-1:0]    bm_wdata, bm_rdata;
    logic               tab_we;
    logic [SW-1:0]      tab_waddr, tab_raddr;
    logic [TW-1:0]      tab_wdata, tab_rdata;
    logic               idx_we;
    logic [SW+EW-1:0]   idx_waddr, idx_raddr;
    logic [BLKW-1:0]    idx_wdata, idx_rdata;

    logic               can_emit;
    logic               emit;
    logic               accept;
    logic [SZW-1:0]     n_clamp;
    logic [WORD-1:0]    low_bit;
    logic [WORD-1:0]    word_next;
    logic               scan_emit;
    logic [SW-1:0]      slot_inc;
    logic [15:0]        tab_key;
    logic [SZW-1:0]     tab_size;

    assign can_emit  = !r_out_valid || !i_out_stall;
    // output register must be empty so a new request cannot disturb a held beat
    assign accept    = i_in_valid && (r_state == S_IDLE) && !r_out_valid;
    assign n_clamp   = (i_block_count > 8'(BLOCKS_PER_FILE)) ? SZW'(BLOCKS_PER_FILE)
                                                              : SZW'(i_block_count);
    assign low_bit   = r_word & (~r_word + WORD'(1));
    assign word_next = r_word & ~low_bit;
    assign scan_emit = (r_word != '0) && can_emit;
    assign emit      = ((r_state == S_RESP) && can_emit)
                    || ((r_state == S_A_SCAN) && scan_emit);
    assign slot_inc  = r_slot + SW'(1);
    assign tab_key   = tab_rdata[TW-1:SZW];
    assign tab_size  = tab_rdata[SZW-1:0];

    ibal_ram #(.W(WORD), .A(RW)) u_bitmap (
        .i_clk(i_clk), .i_we(bm_we), .i_waddr(bm_waddr), .i_wdata(bm_wdata),
        .i_raddr(bm_raddr), .o_rdata(bm_rdata)
    );

    ibal_ram #(.W(TW), .A(SW)) u_table (
        .i_clk(i_clk), .i_we(tab_we), .i_waddr(tab_waddr), .i_wdata(tab_wdata),
        .i_raddr(tab_raddr), .o_rdata(tab_rdata)
    );

    ibal_ram #(.W(BLKW), .A(SW + EW)) u_index (
        .i_clk(i_clk), .i_we(idx_we), .i_waddr(idx_waddr), .i_wdata(idx_wdata),
        .i_raddr(idx_raddr), .o_rdata(idx_rdata)
    );

    // memory port steering
    always_comb begin
        bm_we     = 1'b0;
        bm_waddr  = r_row;
        bm_wdata  = word_next;
        bm_raddr  = r_row;
        tab_we    = 1'b0;
        tab_waddr = r_slot;
        tab_wdata = tab_rdata;
        tab_raddr = r_slot;
        idx_we    = 1'b0;
        idx_waddr = {r_slot, r_cnt[EW-1:0]};
        idx_wdata = idx_rdata;
        idx_raddr = {r_slot, r_cnt[EW-1:0]};
        unique case (r_state)
            S_CLEAR: begin
                bm_we    = 1'b1;
                bm_wdata = (r_row == RW'(ROWS - 1)) ? LAST_MASK : '1;
            end
            S_IDLE: begin
                // record the new file once the request is known to succeed
                if (accept && t_mode'(i_mode) == MODE_ALLOC && r_files != FW'(FILE_SLOTS)
                    && CW'(n_clamp) <= CW'(r_free)) begin
                    tab_we    = 1'b1;
                    tab_waddr = r_files[SW-1:0];
                    tab_wdata = {i_file_key, n_clamp};
                end
            end
            S_A_SCAN: begin
                bm_we     = (r_word == '0) || (scan_emit && (r_cnt + SZW'(1) == r_n));
                idx_we    = scan_emit;
                idx_wdata = BLKW'({r_row, f_onehot_idx(low_bit)});
            end
            S_LK_RD: begin
                idx_raddr = {r_slot, r_entry[EW-1:0]};
            end
            S_DF_BRD: begin
                bm_raddr = r_bm_row;
            end
            S_DF_BMOD: begin
                bm_we    = 1'b1;
                bm_waddr = r_bm_row;
                bm_wdata = bm_rdata | (WORD'(1) << r_bm_bit);
            end
            S_CP_TRD: begin
                tab_raddr = slot_inc;
            end
            S_CP_TAB: begin
                tab_we = 1'b1;
            end
            S_CP_IRD: begin
                idx_raddr = {slot_inc, r_cnt[EW-1:0]};
            end
            S_CP_IWR: begin
                idx_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_row       <= '0;
            r_files     <= '0;
            r_free      <= FTW'(DISK_BLOCKS);
            r_out_valid <= 1'b0;
        end else begin
            // beat leaves when taken, a new one loads when emitted
            r_out_valid <= emit || (r_out_valid && i_out_stall);
            unique case (r_state)
                S_CLEAR: begin
                    if (r_row == RW'(ROWS - 1)) begin
                        r_state <= S_IDLE;
                    end
                    r_row <= r_row + RW'(1);
                end
                S_IDLE: begin
                    if (accept) begin
                        r_key   <= i_file_key;
                        r_mode  <= t_mode'(i_mode);
                        r_entry <= i_entry_index;
                        r_n     <= n_clamp;
                        r_cnt   <= '0;
                        r_blk   <= '0;
                        r_last  <= 1'b1;
                        unique case (t_mode'(i_mode))
                            MODE_ALLOC: begin
                                if (r_files == FW'(FILE_SLOTS)) begin
                                    r_status <= ST_TABLE_FULL;
                                    r_fb     <= '0;
                                    r_state  <= S_RESP;
                                end else if (CW'(n_clamp) > CW'(r_free)) begin
                                    r_status <= ST_DISK_FULL;
                                    r_fb     <= n_clamp;
                                    r_state  <= S_RESP;
                                end else begin
                                    r_status <= ST_OK;
                                    r_fb     <= '0;
                                    r_slot   <= r_files[SW-1:0];
                                    r_files  <= r_files + FW'(1);
                                    r_row    <= '0;
                                    r_state  <= (n_clamp != '0) ? S_A_RD : S_RESP;
                                end
                            end
                            MODE_DELETE, MODE_LOOKUP: begin
                                r_slot <= '0;
                                if (r_files == '0) begin
                                    r_status <= ST_NOT_FOUND;
                                    r_fb     <= '0;
                                    r_state  <= S_RESP;
                                end else begin
                                    r_state <= S_FIND_RD;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_RESP: begin
                    if (can_emit) begin
                        r_state <= S_IDLE;
                    end
                end
                S_A_RD: begin
                    r_state <= S_A_LOAD;
                end
                S_A_LOAD: begin
                    r_word  <= bm_rdata;
                    r_state <= S_A_SCAN;
                end
                S_A_SCAN: begin
                    if (r_word == '0) begin
                        r_row   <= r_row + RW'(1);
                        r_state <= S_A_RD;
                    end else if (can_emit) begin
                        r_word      <= word_next;
                        r_status    <= ST_OK;
                        r_blk       <= BLKW'({r_row, f_onehot_idx(low_bit)});
                        r_fb        <= r_n;
                        r_last      <= (r_cnt + SZW'(1) == r_n);
                        r_cnt       <= r_cnt + SZW'(1);
                        if (r_cnt + SZW'(1) == r_n) begin
                            r_free  <= r_free - FTW'(r_n);
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_FIND_RD: begin
                    r_state <= S_FIND_CMP;
                end
                S_FIND_CMP: begin
                    if (tab_key == r_key) begin
                        r_size <= tab_size;
                        r_fb   <= tab_size;
                        if (r_mode == MODE_LOOKUP) begin
                            if (SZW'(r_entry) >= tab_size) begin
                                r_status <= ST_RANGE;
                                r_state  <= S_RESP;
                            end else begin
                                r_state <= S_LK_RD;
                            end
                        end else if (FW'(r_slot) + FW'(1) == r_files) begin
                            // a match in the last slot needs no move
                            r_files  <= r_files - FW'(1);
                            r_status <= ST_OK;
                            r_state  <= (tab_size == '0) ? S_RESP : S_DF_RD;
                        end else begin
                            r_state <= (tab_size == '0) ? S_CP_TRD : S_DF_RD;
                        end
                    end else if (FW'(r_slot) + FW'(1) == r_files) begin
                        r_status <= ST_NOT_FOUND;
                        r_fb     <= '0;
                        r_state  <= S_RESP;
                    end else begin
                        r_slot  <= slot_inc;
                        r_state <= S_FIND_RD;
                    end
                end
                S_LK_RD: begin
                    r_state <= S_LK_OUT;
                end
                S_LK_OUT: begin
                    r_status <= ST_OK;
                    r_blk    <= idx_rdata;
                    r_state  <= S_RESP;
                end
                S_DF_RD: begin
                    r_state <= S_DF_IDX;
                end
                S_DF_IDX: begin
                    r_bm_row <= idx_rdata[BLKW-1:WBITS];
                    r_bm_bit <= idx_rdata[WBITS-1:0];
                    r_state  <= S_DF_BRD;
                end
                S_DF_BRD: begin
                    r_state <= S_DF_BMOD;
                end
                S_DF_BMOD: begin
                    r_free <= r_free + FTW'(1);
                    r_cnt  <= r_cnt + SZW'(1);
                    if (r_cnt + SZW'(1) == r_size) begin
                        r_status <= ST_OK;
                        if (FW'(r_slot) == r_files) begin
                            // last slot already dropped at the match
                            r_state <= S_RESP;
                        end else begin
                            r_state <= S_CP_TRD;
                        end
                    end else begin
                        r_state <= S_DF_RD;
                    end
                end
                S_CP_TRD: begin
                    r_state <= S_CP_TAB;
                end
                S_CP_TAB: begin
                    r_csize <= tab_size;
                    r_cnt   <= '0;
                    if (tab_size == '0) begin
                        r_slot <= slot_inc;
                        if (FW'(slot_inc) + FW'(1) == r_files) begin
                            r_files  <= r_files - FW'(1);
                            r_status <= ST_OK;
                            r_state  <= S_RESP;
                        end else begin
                            r_state <= S_CP_TRD;
                        end
                    end else begin
                        r_state <= S_CP_IRD;
                    end
                end
                S_CP_IRD: begin
                    r_state <= S_CP_IWR;
                end
                S_CP_IWR: begin
                    if (r_cnt + SZW'(1) == r_csize) begin
                        r_slot <= slot_inc;
                        if (FW'(slot_inc) + FW'(1) == r_files) begin
                            r_files  <= r_files - FW'(1);
                            r_status <= ST_OK;
                            r_state  <= S_RESP;
                        end else begin
                            r_state <= S_CP_TRD;
                        end
                    end else begin
                        r_cnt   <= r_cnt + SZW'(1);
                        r_state <= S_CP_IRD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall     = (r_state != S_IDLE) || r_out_valid;
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_block_number = OBLK'(r_blk);
    assign o_file_blocks  = r_fb;
    assign o_last         = r_last;

endmodule

`default_nettype wire

### design/ibal_ram.sv
// ----------------------------------------------------------------------------
// ibal_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ibal_ram #(
    parameter int W = 8,
    parameter int A = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_we,
    input  wire logic [A-1:0] i_waddr,
    input  wire logic [W-1:0] i_wdata,
    input  wire logic [A-1:0] i_raddr,
    output logic      [W-1:0] o_rdata
);

    logic [W-1:0] r_mem [2**A];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### design/ibal_checker.sv
// ----------------------------------------------------------------------------
// ibal_checker
// Port-level checks of the indexed block allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ibal_checker
    import ibal_pkg::*;
(
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            o_in_stall,
    input wire logic            o_out_valid,
    input wire logic            i_out_stall,
    input wire logic [2:0]      o_status,
    input wire logic [OBLK-1:0] o_block_number,
    input wire logic [SZW-1:0]  o_file_blocks,
    input wire logic            o_last
);

    // held output beat keeps its status, block number and last flag
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
        && $stable(o_block_number) && $stable(o_last))
        else $error("stalled output beat changed");

    // clearing pass follows reset
    a_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("request taken during clearing pass");

    // only granted blocks come before the final beat
    a_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> o_status == ST_OK)
        else $error("error status on a non-final beat");

    // table-full and not-found refusals carry no block and no size
    a_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_TABLE_FULL || o_status == ST_NOT_FOUND)
        |-> o_block_number == '0 && o_file_blocks == '0 && o_last)
        else $error("refusal beat with payload");

endmodule

bind indexed_block_allocator ibal_checker u_ibal_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_in_stall(o_in_stall),
    .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_status(o_status),
    .o_block_number(o_block_number), .o_file_blocks(o_file_blocks), .o_last(o_last)
);

`default_nettype wire
